/* src/hhlc_pkg.sv */
// shared constants and types for the http header line checker
`default_nettype none

package hhlc_pkg;

   // default width of the name and value length counters
   localparam int unsigned LEN_WIDTH_DEFAULT = 16;

   // width of the limit registers
   localparam int unsigned LIMIT_WIDTH = 16;

   // configuration register indexes (byte address is 4 * index)
   typedef enum logic [1:0] {
      REG_NAME_LIMIT_ON  = 2'd0,
      REG_NAME_LIMIT     = 2'd1,
      REG_VALUE_LIMIT_ON = 2'd2,
      REG_VALUE_LIMIT    = 2'd3
   } reg_index_type;

   // line status reported on the final word
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_SEP     = 3'd1,
      ST_NAME_LONG  = 3'd2,
      ST_VALUE_LONG = 3'd3,
      ST_NAME_BAD   = 3'd4,
      ST_VALUE_BAD  = 3'd5
   } status_type;

   // characters of interest
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_DEL       = 8'h7F;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0   = 8'h30;
   localparam logic [7:0] CH_DIGIT_9   = 8'h39;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

endpackage

`default_nettype wire

/* src/http_header_line_checker_unit.sv */
// top level of the http header line checker: byte parser, output skid and csr port
//
// usage
//  - req channel carries one byte of a header line per word; req_tlast marks the
//    final byte of the line
//  - rsp channel returns one word per input word: the byte (lowercased while in the
//    header name), rsp_tuser set for bytes after the ": " separator, rsp_tlast on the
//    final byte, and a status in rsp_tdata[10:8] on that final word (zero elsewhere)
//  - status: ok, no separator, name long, value long, bad name, bad value, first
//    matching check wins
//  - csr port: name_limit_on at 0x0, name_limit at 0x4, value_limit_on at 0x8,
//    value_limit at 0xc; write only while no line is in flight
// timing
//  - each result is registered in the output register before rsp_tvalid rises
//  - one word per cycle while the receiver keeps up; the parse state is a few flops
//    updated once per accepted word, with a single compare per limit on the final byte
// reset and stall
//  - reset drops both valids, clears the parse state and loads the register defaults
//  - when the receiver stalls, an output register plus one skid entry hold results;
//    req_tready drops only once the skid entry is occupied
`default_nettype none

module http_header_line_checker_unit #(
   parameter int unsigned LEN_WIDTH = hhlc_pkg::LEN_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // line_end

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [10:8] status, rest zero
   output logic             rsp_tlast,   // done_res
   output logic             rsp_tuser,   // in_value

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int unsigned LW    = hhlc_pkg::LIMIT_WIDTH;
   localparam int unsigned CMP_W = (LEN_WIDTH > LW) ? LEN_WIDTH : LW;
   localparam logic [LEN_WIDTH-1:0] CNT_MAX = {LEN_WIDTH{1'b1}};

   // parse phase
   typedef enum logic [1:0] {
      PH_NAME  = 2'd0,
      PH_COLON = 2'd1,
      PH_VALUE = 2'd2,
      PH_SPARE = 2'd3
   } phase_type;

   // one result word
   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 in_value;
      logic                 done_res;
      hhlc_pkg::status_type status;
   } result_type;

   // configuration registers
   logic          name_limit_on_ff;
   logic [LW-1:0] name_limit_ff;
   logic          value_limit_on_ff;
   logic [LW-1:0] value_limit_ff;

   // parse state
   phase_type              phase_ff,       phase_in;
   logic [LEN_WIDTH-1:0]   name_count_ff,  name_count_in;
   logic [LEN_WIDTH-1:0]   value_count_ff, value_count_in;
   logic                   name_bad_ff,    name_bad_in;
   logic                   value_bad_ff,   value_bad_in;

   // output register and skid entry
   logic       out_valid_ff;
   result_type out_data_ff;
   logic       skid_valid_ff;
   result_type skid_data_ff;

   result_type res_in;
   logic       accept;
   logic       pop;
   logic       csr_write;

   // saturating increment of a length counter
   function automatic logic [LEN_WIDTH-1:0] sat_inc(input logic [LEN_WIDTH-1:0] c);
      sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   // letters, digits and dash are legal in a header name
   function automatic logic name_char_ok(input logic [7:0] b);
      name_char_ok = ((b >= hhlc_pkg::CH_UPPER_A) && (b <= hhlc_pkg::CH_UPPER_Z)) ||
                     ((b >= hhlc_pkg::CH_LOWER_A) && (b <= hhlc_pkg::CH_LOWER_Z)) ||
                     ((b >= hhlc_pkg::CH_DIGIT_0) && (b <= hhlc_pkg::CH_DIGIT_9)) ||
                     (b == hhlc_pkg::CH_DASH);
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = !skid_valid_ff;

   // ---------------------------------------------------------------- parse step
   always_comb begin
      logic [7:0]           b;
      logic                 is_upper;
      logic [LEN_WIDTH-1:0] name_base;
      logic                 bad_base;
      hhlc_pkg::status_type st;

      b        = req_tdata;
      is_upper = (b >= hhlc_pkg::CH_UPPER_A) && (b <= hhlc_pkg::CH_UPPER_Z);

      phase_in       = phase_ff;
      name_count_in  = name_count_ff;
      value_count_in = value_count_ff;
      name_bad_in    = name_bad_ff;
      value_bad_in   = value_bad_ff;
      name_base      = name_count_ff;
      bad_base       = name_bad_ff;

      res_in.out_byte = b;
      res_in.in_value = 1'b0;
      res_in.done_res = req_tlast;

      if (phase_ff == PH_VALUE) begin
         res_in.in_value = 1'b1;
         value_count_in  = sat_inc(value_count_ff);
         if ((b < hhlc_pkg::CH_SPACE) || (b >= hhlc_pkg::CH_DEL)) begin
            value_bad_in = 1'b1;
         end
      end else begin
         if (is_upper) begin
            res_in.out_byte = b + hhlc_pkg::CASE_OFFSET;
         end
         if ((phase_ff == PH_COLON) && (b == hhlc_pkg::CH_SPACE)) begin
            phase_in = PH_VALUE;
         end else begin
            // a pending colon without a space joins the name and spoils it
            if (phase_ff == PH_COLON) begin
               name_base = sat_inc(name_count_ff);
               bad_base  = 1'b1;
            end
            name_count_in = name_base;
            name_bad_in   = bad_base;
            if (b == hhlc_pkg::CH_COLON) begin
               phase_in = PH_COLON;
            end else begin
               phase_in      = PH_NAME;
               name_count_in = sat_inc(name_base);
               if (!name_char_ok(b)) begin
                  name_bad_in = 1'b1;
               end
            end
         end
      end

      // final status, priority order
      if (phase_in != PH_VALUE) begin
         st = hhlc_pkg::ST_NO_SEP;
      end else if (name_limit_on_ff &&
                   (CMP_W'(name_count_in) > CMP_W'(name_limit_ff))) begin
         st = hhlc_pkg::ST_NAME_LONG;
      end else if (value_limit_on_ff &&
                   (CMP_W'(value_count_in) > CMP_W'(value_limit_ff))) begin
         st = hhlc_pkg::ST_VALUE_LONG;
      end else if ((name_count_in == '0) || name_bad_in) begin
         st = hhlc_pkg::ST_NAME_BAD;
      end else if (value_bad_in) begin
         st = hhlc_pkg::ST_VALUE_BAD;
      end else begin
         st = hhlc_pkg::ST_OK;
      end
      res_in.status = req_tlast ? st : hhlc_pkg::ST_OK;
   end

   // parse state registers; a finished line starts over
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_NAME;
         name_count_ff  <= '0;
         value_count_ff <= '0;
         name_bad_ff    <= 1'b0;
         value_bad_ff   <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            phase_ff       <= PH_NAME;
            name_count_ff  <= '0;
            value_count_ff <= '0;
            name_bad_ff    <= 1'b0;
            value_bad_ff   <= 1'b0;
         end else begin
            phase_ff       <= phase_in;
            name_count_ff  <= name_count_in;
            value_count_ff <= value_count_in;
            name_bad_ff    <= name_bad_in;
            value_bad_ff   <= value_bad_in;
         end
      end
   end

   // ---------------------------------------------------------------- output skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // input is blocked; drain the skid entry into the output register
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= res_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= res_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_data_ff.status, out_data_ff.out_byte};
   assign rsp_tlast  = out_data_ff.done_res;
   assign rsp_tuser  = out_data_ff.in_value;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_limit_on_ff  <= 1'b0;
         name_limit_ff     <= '1;
         value_limit_on_ff <= 1'b0;
         value_limit_ff    <= '1;
      end else if (csr_write) begin
         case (hhlc_pkg::reg_index_type'(csr_paddr[3:2]))
            hhlc_pkg::REG_NAME_LIMIT_ON:  name_limit_on_ff  <= csr_pwdata[0];
            hhlc_pkg::REG_NAME_LIMIT:     name_limit_ff     <= csr_pwdata[LW-1:0];
            hhlc_pkg::REG_VALUE_LIMIT_ON: value_limit_on_ff <= csr_pwdata[0];
            hhlc_pkg::REG_VALUE_LIMIT:    value_limit_ff    <= csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (hhlc_pkg::reg_index_type'(csr_paddr[3:2]))
         hhlc_pkg::REG_NAME_LIMIT_ON:  csr_prdata = {31'd0, name_limit_on_ff};
         hhlc_pkg::REG_NAME_LIMIT:     csr_prdata = 32'(name_limit_ff);
         hhlc_pkg::REG_VALUE_LIMIT_ON: csr_prdata = {31'd0, value_limit_on_ff};
         hhlc_pkg::REG_VALUE_LIMIT:    csr_prdata = 32'(value_limit_ff);
         default:                      csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire
